[hdl/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// modexp_pkg: shared types, constants and microcode for modular exponentiation
// Holds the datapath widths, the micro-op and jump codes, and the control
// store that the sequencer steps through.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// datapath word width; exponent and multiplier bits scan the low WORD_BITS-1
	localparam int WORD_BITS  = 64;
	localparam int SCAN_BITS  = WORD_BITS - 1;
	// fixed widths of the stream fields
	localparam int FIELD_BITS = 63;
	localparam int DP_BITS    = FIELD_BITS + 1;
	localparam int CNT_BITS   = $clog2(FIELD_BITS);
	localparam int IN_BYTES   = (3 * FIELD_BITS + 7) / 8;
	localparam int OUT_BYTES  = (FIELD_BITS + 7) / 8;

	localparam logic [FIELD_BITS-1:0] SCAN_MASK =
		FIELD_BITS'((65'd1 << SCAN_BITS) - 65'd1);
	// a zero modulus stands for 2^63
	localparam logic [DP_BITS-1:0] ZERO_MOD = DP_BITS'(65'd1 << FIELD_BITS);
	localparam logic [CNT_BITS-1:0] RED_LAST  = CNT_BITS'(FIELD_BITS - 1);
	localparam logic [CNT_BITS-1:0] SCAN_LAST = CNT_BITS'(SCAN_BITS - 1);

	// micro-ops driving the datapath
	typedef enum logic [2:0] {
		OP_LOAD,    // take an input transfer
		OP_RED,     // one restoring step of base mod modulus
		OP_SETUP,   // square register from remainder, accumulator to 1 mod m
		OP_MINIT_A, // start accumulator times square
		OP_MINIT_S, // start square times square
		OP_MSTEP,   // one shift-and-add modular multiply step
		OP_ACC_WB,  // product into accumulator
		OP_SQ_WB    // product into square, next exponent bit
	} op_t;

	// jump conditions; taken means go to target, else to nxt
	typedef enum logic [2:0] {
		C_NONE,
		C_NO_IN,
		C_CNT,
		C_EZERO,
		C_NOT_EBIT0,
		C_EMORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [3:0] pc_t;

	localparam pc_t PC_IDLE    = 4'd0;
	localparam pc_t PC_RED     = 4'd1;
	localparam pc_t PC_CHK     = 4'd2;
	localparam pc_t PC_MA_INIT = 4'd3;
	localparam pc_t PC_MA_STEP = 4'd4;
	localparam pc_t PC_MA_WB   = 4'd5;
	localparam pc_t PC_SQ_INIT = 4'd6;
	localparam pc_t PC_SQ_STEP = 4'd7;
	localparam pc_t PC_SQ_WB   = 4'd8;
	localparam pc_t PC_OUT     = 4'd9;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		pc_t   nxt;
		logic  emit;
	} ucode_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic cnt_zero;
		logic e_zero;
		logic e_bit0;
		logic e_more;
	} status_t;

	// control store
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_IDLE:    w = '{OP_LOAD,    C_NO_IN,     PC_IDLE,    PC_RED,     1'b0};
			PC_RED:     w = '{OP_RED,     C_CNT,       PC_RED,     PC_CHK,     1'b0};
			PC_CHK:     w = '{OP_SETUP,   C_EZERO,     PC_OUT,     PC_MA_INIT, 1'b0};
			PC_MA_INIT: w = '{OP_MINIT_A, C_NOT_EBIT0, PC_SQ_INIT, PC_MA_STEP, 1'b0};
			PC_MA_STEP: w = '{OP_MSTEP,   C_CNT,       PC_MA_STEP, PC_MA_WB,   1'b0};
			PC_MA_WB:   w = '{OP_ACC_WB,  C_NONE,      PC_SQ_INIT, PC_SQ_INIT, 1'b0};
			PC_SQ_INIT: w = '{OP_MINIT_S, C_NONE,      PC_SQ_STEP, PC_SQ_STEP, 1'b0};
			PC_SQ_STEP: w = '{OP_MSTEP,   C_CNT,       PC_SQ_STEP, PC_SQ_WB,   1'b0};
			PC_SQ_WB:   w = '{OP_SQ_WB,   C_EMORE,     PC_MA_INIT, PC_OUT,     1'b0};
			PC_OUT:     w = '{OP_LOAD,    C_OUT_BUSY,  PC_OUT,     PC_IDLE,    1'b1};
			default:    w = '{OP_LOAD,    C_NONE,      PC_IDLE,    PC_IDLE,    1'b0};
		endcase
		return w;
	endfunction

endpackage

[hdl/modexp_seq.sv]
// ----------------------------------------------------------------------------
// modexp_seq: microcode sequencer
// Steps a program counter through the control store and resolves the
// conditional jumps from the datapath flags.
// ----------------------------------------------------------------------------
module modexp_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  modexp_pkg::status_t status,
	output modexp_pkg::ucode_t  uword
);

	modexp_pkg::pc_t pc_q;
	logic            take;

	// current control word
	assign uword = modexp_pkg::ucode_rom(pc_q);

	// jump condition
	always_comb begin
		unique case (uword.cond)
			modexp_pkg::C_NONE:      take = 1'b0;
			modexp_pkg::C_NO_IN:     take = !status.in_valid;
			modexp_pkg::C_CNT:       take = !status.cnt_zero;
			modexp_pkg::C_EZERO:     take = status.e_zero;
			modexp_pkg::C_NOT_EBIT0: take = !status.e_bit0;
			modexp_pkg::C_EMORE:     take = status.e_more;
			modexp_pkg::C_OUT_BUSY:  take = !status.out_free;
			default:                 take = 1'b0;
		endcase
	end

	// program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= modexp_pkg::PC_IDLE;
		end else begin
			pc_q <= take ? uword.target : uword.nxt;
		end
	end

endmodule

[hdl/modular_exponentiation_unit.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base^exponent mod modulus
// Right-to-left square and multiply; every modular product is formed by a
// bit-serial shift-and-add multiplier under microcode control.
//
// channel  | direction | tdata fields (low bit up)
// s_axis   | in        | base [62:0], exponent [125:63], modulus [188:126]
// m_axis   | out       | power_result [62:0]
//
// One item is loaded and its base reduced, then each exponent bit takes a
// squaring and, where the bit is set, a multiply first, up to the highest set
// bit (at most 63 bits), each product from the 63-step shift-and-add
// multiplier loop; the result is then loaded into the output register.
// Reset clears the sequencer and output valid.
// The result waits in the output register; the next item is taken only after
// the current result is loaded there, even if it has not yet been read out.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// base, exponent, modulus (63 bits each), zero fill
	input  logic [8*modexp_pkg::IN_BYTES-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// power_result (63 bits), zero fill
	output logic [8*modexp_pkg::OUT_BYTES-1:0]  m_axis_tdata
);

	localparam int FB = modexp_pkg::FIELD_BITS;
	localparam int DB = modexp_pkg::DP_BITS;
	localparam int CB = modexp_pkg::CNT_BITS;

	modexp_pkg::status_t status;
	modexp_pkg::ucode_t  uword;

	logic [FB-1:0] base_q;
	logic [FB-1:0] exp_q;
	logic [DB-1:0] mod_q;
	logic [DB-1:0] rem_q;
	logic [FB-1:0] acc_q;
	logic [FB-1:0] sq_q;
	logic [DB-1:0] addend_q;
	logic [FB-1:0] mult_q;
	logic [DB-1:0] prod_q;
	logic [CB-1:0] cnt_q;
	logic [CB-1:0] ecnt_q;
	logic [FB-1:0] out_data_q;
	logic          out_valid_q;

	logic [FB-1:0] in_base;
	logic [FB-1:0] in_exp;
	logic [FB-1:0] in_mod;
	logic          in_xfer;
	logic          out_free;
	logic          emit;
	logic [DB-1:0] rem_shift;
	logic [DB-1:0] rem_next;
	logic [DB-1:0] sum;
	logic [DB-1:0] sum_red;
	logic [DB-1:0] dbl;
	logic [DB-1:0] dbl_red;

	modexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uword  (uword)
	);

	// input field unpacking
	assign in_base = s_axis_tdata[FB-1:0];
	assign in_exp  = s_axis_tdata[2*FB-1:FB];
	assign in_mod  = s_axis_tdata[3*FB-1:2*FB];

	// handshakes
	assign s_axis_tready = (uword.op == modexp_pkg::OP_LOAD) && !uword.emit;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign emit          = uword.emit && out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8*modexp_pkg::OUT_BYTES-FB){1'b0}}, out_data_q};

	// sequencer flags
	assign status.in_valid = s_axis_tvalid;
	assign status.out_free = out_free;
	assign status.cnt_zero = (cnt_q == '0);
	assign status.e_zero   = (exp_q == '0);
	assign status.e_bit0   = exp_q[0];
	assign status.e_more   = (ecnt_q != '0) && (exp_q[FB-1:1] != '0);

	// restoring reduction step for base mod modulus
	assign rem_shift = {rem_q[DB-2:0], base_q[FB-1]};
	assign rem_next  = (rem_shift >= mod_q) ? rem_shift - mod_q : rem_shift;

	// shift-and-add multiply step: add and double, each reduced once
	assign sum     = prod_q + addend_q;
	assign sum_red = (sum >= mod_q) ? sum - mod_q : sum;
	assign dbl     = {addend_q[DB-2:0], 1'b0};
	assign dbl_red = (dbl >= mod_q) ? dbl - mod_q : dbl;

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (uword.op)
			modexp_pkg::OP_LOAD: begin
				if (in_xfer) begin
					base_q <= in_base;
					exp_q  <= in_exp & modexp_pkg::SCAN_MASK;
					mod_q  <= (in_mod == '0) ? modexp_pkg::ZERO_MOD : {1'b0, in_mod};
					rem_q  <= '0;
					cnt_q  <= modexp_pkg::RED_LAST;
				end
			end
			modexp_pkg::OP_RED: begin
				rem_q  <= rem_next;
				base_q <= {base_q[FB-2:0], 1'b0};
				cnt_q  <= cnt_q - CB'(1);
			end
			modexp_pkg::OP_SETUP: begin
				sq_q   <= rem_q[FB-1:0];
				acc_q  <= (exp_q != '0 && mod_q == DB'(1)) ? '0 : FB'(1);
				ecnt_q <= modexp_pkg::SCAN_LAST;
			end
			modexp_pkg::OP_MINIT_A: begin
				addend_q <= {1'b0, acc_q};
				mult_q   <= sq_q;
				prod_q   <= '0;
				cnt_q    <= modexp_pkg::SCAN_LAST;
			end
			modexp_pkg::OP_MINIT_S: begin
				addend_q <= {1'b0, sq_q};
				mult_q   <= sq_q;
				prod_q   <= '0;
				cnt_q    <= modexp_pkg::SCAN_LAST;
			end
			modexp_pkg::OP_MSTEP: begin
				if (mult_q[0]) begin
					prod_q <= sum_red;
				end
				addend_q <= dbl_red;
				mult_q   <= {1'b0, mult_q[FB-1:1]};
				cnt_q    <= cnt_q - CB'(1);
			end
			modexp_pkg::OP_ACC_WB: begin
				acc_q <= prod_q[FB-1:0];
			end
			modexp_pkg::OP_SQ_WB: begin
				sq_q   <= prod_q[FB-1:0];
				exp_q  <= {1'b0, exp_q[FB-1:1]};
				ecnt_q <= ecnt_q - CB'(1);
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= acc_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
